[rtl/core/countdown_timer_with_percent_top_macros.svh]
// ----------------------------------------------------------------------------
// Countdown timer assertion macros
// Shared concurrent assertion forms for the countdown timer checkers.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_WITH_PERCENT_TOP_MACROS_SVH
`define COUNTDOWN_TIMER_WITH_PERCENT_TOP_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define CTP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define CTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ctp_pkg.sv]
// ----------------------------------------------------------------------------
// Countdown timer package
// Types, operation and mode codes, and fixed widths of the countdown timer.
// ----------------------------------------------------------------------------
package ctp_pkg;

   localparam int OP_W      = 3;
   localparam int SECONDS_W = 18;
   localparam int PCT_W     = 14;
   localparam int MODE_W    = 2;
   localparam int TPS_W     = 7;
   localparam int TICK_W    = 25;
   localparam int STEP_W    = $clog2(TICK_W + 1);

   localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(10);

   typedef logic [TPS_W-1:0] tps_type;

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 3'd0,
      OP_CREATE = 3'd1,
      OP_START  = 3'd2,
      OP_PAUSE  = 3'd3,
      OP_RESUME = 3'd4,
      OP_RESET  = 3'd5
   } op_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_RESET   = 2'd0,
      MODE_RUNNING = 2'd1,
      MODE_PAUSED  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [OP_W-1:0]      operation;
      logic [SECONDS_W-1:0] seconds_to_load;
   } req_payload_type;

   typedef struct packed {
      logic [SECONDS_W-1:0] seconds_left;
      logic [PCT_W-1:0]     percent_left;
      logic [MODE_W-1:0]    mode;
      logic                 exists;
      logic                 ticking;
      logic                 timed_out;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_SEC,
      ST_SPAN,
      ST_NUM,
      ST_DIV,
      ST_PCT,
      ST_OUT
   } ctp_state_type;

   typedef struct packed {
      logic apply;
      logic div_step;
      logic second;
      logic span_load;
      logic num_load;
      logic pct_store;
      logic capture;
   } ctp_cmd_type;

   typedef struct packed {
      logic tick_go;
      logic div_last;
      logic keep_going;
      logic span_ok;
   } ctp_status_type;

endpackage

[rtl/core/ctp_stream_if.sv]
// ----------------------------------------------------------------------------
// Countdown timer stream interface
// Valid/ready channel carrying one payload of a configurable type.
// ----------------------------------------------------------------------------
interface ctp_stream_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

[rtl/core/ctp_ctrl.sv]
// ----------------------------------------------------------------------------
// Countdown timer controller
// Sequences one request through the datapath and owns the result handshake.
// ----------------------------------------------------------------------------
module ctp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ctp_pkg::ctp_status_type status,
   output ctp_pkg::ctp_cmd_type    cmd
);
   import ctp_pkg::*;

   ctp_state_type state_ff;
   ctp_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.apply = 1'b1;
               state_in  = status.tick_go ? ST_MOD : ST_OUT;
            end
         end
         ST_MOD: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SEC;
            end
         end
         ST_SEC: begin
            cmd.second = 1'b1;
            state_in   = status.keep_going ? ST_SPAN : ST_OUT;
         end
         ST_SPAN: begin
            cmd.span_load = 1'b1;
            state_in      = ST_NUM;
         end
         ST_NUM: begin
            cmd.num_load = 1'b1;
            state_in     = status.span_ok ? ST_DIV : ST_OUT;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_PCT;
            end
         end
         ST_PCT: begin
            cmd.pct_store = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.capture | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/core/ctp_datapath.sv]
// ----------------------------------------------------------------------------
// Countdown timer datapath
// Countdown state, tick-per-second register, shared serial divider and the
// result register.
// ----------------------------------------------------------------------------
module ctp_datapath #(
   parameter int COUNT_WIDTH  = 18,
   parameter int PERCENT_FULL = 10000
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctp_pkg::ctp_cmd_type     cmd,
   output ctp_pkg::ctp_status_type  status,
   input  ctp_pkg::req_payload_type req_data,
   input  logic                     csr_we,
   input  ctp_pkg::tps_type         csr_data,
   output ctp_pkg::rsp_payload_type rsp_data
);
   import ctp_pkg::*;

   localparam int SPAN_W  = COUNT_WIDTH + TPS_W;
   localparam int PROD_W  = SPAN_W + PCT_W;
   localparam int MOD_D_W = TPS_W + TICK_W - 1;
   localparam int DIV_W   = (PROD_W > MOD_D_W) ? PROD_W : MOD_D_W;
   localparam logic [PCT_W-1:0] PCT_FULL_C = PCT_W'(PERCENT_FULL);

   tps_type                tps_ff, tps_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [COUNT_WIDTH-1:0] remaining_ff, remaining_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic [PCT_W-1:0]       percent_ff, percent_in;
   mode_type               mode_ff, mode_in;
   logic                   exists_ff, exists_in;
   logic                   ticking_ff, ticking_in;
   logic                   fired_ff, fired_in;
   logic [SPAN_W-1:0]      span_ff, span_in;
   logic [DIV_W-1:0]       rem_ff, rem_in;
   logic [DIV_W-1:0]       dvs_ff, dvs_in;
   logic [PCT_W-1:0]       quo_ff, quo_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   rsp_payload_type        rsp_ff, rsp_in;

   tps_type                tps_eff;
   logic [TICK_W-1:0]      tick_inc;
   logic [COUNT_WIDTH-1:0] load_count;
   logic [DIV_W-1:0]       tick_ext;
   logic [DIV_W-1:0]       span_ext;
   logic [SPAN_W-1:0]      diff;
   logic [PROD_W-1:0]      product;
   logic                   sub_ok;
   logic [DIV_W-1:0]       sub_val;
   logic                   mod_zero;
   logic                   clear_req;

   assign tps_eff    = (tps_ff == '0) ? TPS_W'(1) : tps_ff;
   assign tick_inc   = tick_ff + TICK_W'(1);
   assign load_count = COUNT_WIDTH'(req_data.seconds_to_load);
   assign tick_ext   = DIV_W'(tick_ff);
   assign span_ext   = DIV_W'(span_ff);
   assign diff       = SPAN_W'(span_ext - tick_ext);
   assign product    = PROD_W'(diff) * PROD_W'(PCT_FULL_C);
   assign sub_ok     = (rem_ff >= dvs_ff);
   assign sub_val    = rem_ff - dvs_ff;
   assign mod_zero   = (rem_ff == '0);

   assign status.tick_go    = (op_type'(req_data.operation) == OP_TICK) && ticking_ff;
   assign status.div_last   = (step_ff == STEP_W'(1));
   assign status.keep_going = (remaining_ff > COUNT_WIDTH'(1)) ||
                              ((remaining_ff == COUNT_WIDTH'(1)) && !mod_zero);
   assign status.span_ok    = (span_ff != '0) && (tick_ext < span_ext);

   always_comb begin
      tps_in       = tps_ff;
      tick_in      = tick_ff;
      remaining_in = remaining_ff;
      total_in     = total_ff;
      percent_in   = percent_ff;
      mode_in      = mode_ff;
      exists_in    = exists_ff;
      ticking_in   = ticking_ff;
      fired_in     = fired_ff;
      span_in      = span_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rsp_in       = rsp_ff;
      clear_req    = 1'b0;

      if (csr_we) begin
         tps_in = csr_data;
      end

      if (cmd.apply) begin
         fired_in = 1'b0;
         case (op_type'(req_data.operation))
            OP_TICK: begin
               if (ticking_ff) begin
                  tick_in = tick_inc;
                  rem_in  = DIV_W'(tick_inc);
                  dvs_in  = DIV_W'(tps_eff) << (TICK_W - 1);
                  step_in = STEP_W'(TICK_W);
               end
            end
            OP_CREATE: begin
               if (!exists_ff && (load_count != '0)) begin
                  remaining_in = load_count;
                  total_in     = load_count;
                  percent_in   = PCT_FULL_C;
                  mode_in      = MODE_RUNNING;
                  tick_in      = '0;
               end
            end
            OP_START: begin
               exists_in  = 1'b1;
               ticking_in = 1'b1;
            end
            OP_PAUSE: begin
               mode_in    = MODE_PAUSED;
               ticking_in = 1'b0;
            end
            OP_RESUME: begin
               mode_in    = MODE_RUNNING;
               ticking_in = 1'b1;
            end
            OP_RESET: begin
               clear_req = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (cmd.div_step) begin
         if (sub_ok) begin
            rem_in = sub_val;
         end
         quo_in  = {quo_ff[PCT_W-2:0], sub_ok};
         dvs_in  = dvs_ff >> 1;
         step_in = step_ff - STEP_W'(1);
      end

      if (cmd.second && mod_zero && (remaining_ff != '0)) begin
         if (remaining_ff == COUNT_WIDTH'(1)) begin
            clear_req = 1'b1;
            fired_in  = 1'b1;
         end else begin
            remaining_in = remaining_ff - COUNT_WIDTH'(1);
         end
      end

      if (cmd.span_load) begin
         span_in = SPAN_W'(total_ff) * SPAN_W'(tps_eff);
      end

      if (cmd.num_load) begin
         if (status.span_ok) begin
            rem_in  = DIV_W'(product);
            dvs_in  = DIV_W'(span_ff) << (PCT_W - 1);
            step_in = STEP_W'(PCT_W);
         end else begin
            percent_in = '0;
         end
      end

      if (cmd.pct_store) begin
         percent_in = (quo_ff > PCT_FULL_C) ? PCT_FULL_C : quo_ff;
      end

      if (clear_req) begin
         tick_in      = '0;
         remaining_in = '0;
         total_in     = '0;
         percent_in   = '0;
         mode_in      = MODE_RESET;
         exists_in    = 1'b0;
         ticking_in   = 1'b0;
      end

      if (cmd.capture) begin
         rsp_in.seconds_left = SECONDS_W'(remaining_ff);
         rsp_in.percent_left = percent_ff;
         rsp_in.mode         = mode_ff;
         rsp_in.exists       = exists_ff;
         rsp_in.ticking      = ticking_ff;
         rsp_in.timed_out    = fired_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff       <= TPS_RESET;
         tick_ff      <= '0;
         remaining_ff <= '0;
         total_ff     <= '0;
         percent_ff   <= '0;
         mode_ff      <= MODE_RESET;
         exists_ff    <= 1'b0;
         ticking_ff   <= 1'b0;
         fired_ff     <= 1'b0;
      end else begin
         tps_ff       <= tps_in;
         tick_ff      <= tick_in;
         remaining_ff <= remaining_in;
         total_ff     <= total_in;
         percent_ff   <= percent_in;
         mode_ff      <= mode_in;
         exists_ff    <= exists_in;
         ticking_ff   <= ticking_in;
         fired_ff     <= fired_in;
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= span_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

[rtl/core/countdown_timer_with_percent_top.sv]
// ----------------------------------------------------------------------------
// Countdown timer with remaining percent
// Seconds countdown advanced by tick requests, with a percent-left readout.
// ----------------------------------------------------------------------------
// Requests enter on req_chan (operation, seconds_to_load); every accepted
// request yields exactly one result on rsp_chan showing the state after it.
// csr_chan writes ticks_per_second and is always ready; write it only while
// no request is in flight.
// A tick that updates the percent runs, from acceptance to a valid result,
// a 25-step serial remainder of the tick count by ticks_per_second, a
// multiply for the span, and a 14-step serial divide for the percent, all on
// one shared subtract-and-shift unit. A tick that times out or finds no
// seconds left stops after the remainder, and one whose tick count has
// reached the span stops after the multiply. Every other request, and a tick
// while paused, goes straight to the result register.
// One request is worked on at a time; the next is accepted once the current
// result is in the output register, even if the receiver has not taken it.
// If the receiver stalls, the finished result holds and the block waits
// before publishing the next one.
// Reset clears the countdown, sets ticks_per_second to 10 and drops
// rsp_chan.valid.
// ----------------------------------------------------------------------------
module countdown_timer_with_percent_top #(
   parameter int COUNT_WIDTH  = 18,
   parameter int PERCENT_FULL = 10000
) (
   input logic           clock,
   input logic           reset,
   ctp_stream_if.sink    req_chan,
   ctp_stream_if.source  rsp_chan,
   ctp_stream_if.sink    csr_chan
);
   import ctp_pkg::*;

   ctp_cmd_type     cmd;
   ctp_status_type  status;
   req_payload_type req_data;
   rsp_payload_type rsp_data;
   tps_type         csr_data;
   logic            req_ready;
   logic            rsp_valid;

   assign req_data       = req_chan.payload;
   assign csr_data       = csr_chan.payload;
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.payload = rsp_data;

   ctp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ctp_datapath #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .PERCENT_FULL (PERCENT_FULL)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .csr_we   (csr_chan.valid),
      .csr_data (csr_data),
      .rsp_data (rsp_data)
   );

endmodule

[rtl/core/ctp_checker.sv]
// ----------------------------------------------------------------------------
// Countdown timer port checker
// Watches the top-level channels of the countdown timer over time.
// ----------------------------------------------------------------------------
`include "countdown_timer_with_percent_top_macros.svh"

module ctp_checker #(
   parameter int PERCENT_FULL = 10000
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input ctp_pkg::rsp_payload_type rsp_data
);
   import ctp_pkg::*;

   `CTP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data), "Stalled result changed or dropped.")

   `CTP_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready,
      !req_ready, "Request accepted while another request was in progress.")

   `CTP_ASSERT_IMPLY(a_timeout_clears, clock, reset, rsp_valid && rsp_data.timed_out,
      (rsp_data.seconds_left == '0) && (rsp_data.percent_left == '0) &&
      (rsp_data.mode == MODE_RESET) && !rsp_data.exists && !rsp_data.ticking,
      "Timeout result does not show a cleared countdown.")

   `CTP_ASSERT_IMPLY(a_percent_range, clock, reset, rsp_valid,
      rsp_data.percent_left <= PCT_W'(PERCENT_FULL), "Percent left exceeds full scale.")

   `CTP_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset,
      !rsp_valid, "Result valid right after reset.")

endmodule

bind countdown_timer_with_percent_top ctp_checker #(
   .PERCENT_FULL (PERCENT_FULL)
) u_ctp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.payload)
);
